### rtl/core/mkdlp_pkg.sv
// Package for the multi-key debounce and long-press unit.
// Holds field widths, register codes, reset values and the transaction types.
// No dependencies.
package mkdlp_pkg;

  localparam int RAW_W      = 5;
  localparam int ELAPSED_W  = 8;
  localparam int KEY_W      = 3;
  localparam int DEB_W      = 8;
  localparam int LPT_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [DEB_W-1:0] DEB_RESET = 8'd20;
  localparam logic [LPT_W-1:0] LPT_RESET = 16'd10000;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 8'd1;

  typedef struct packed {
    logic [RAW_W-1:0]     raw_keys;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 take_press;
    logic                 take_long;
  } in_item_t;

  typedef struct packed {
    logic             press_valid;
    logic [KEY_W-1:0] press_key;
    logic             long_valid;
    logic [KEY_W-1:0] long_key;
    logic [RAW_W-1:0] stable_keys;
  } out_item_t;

  typedef struct packed {
    logic press_ev;
    logic long_ev;
    logic stable;
  } lane_stat_t;

endpackage

### rtl/core/mkdlp_lane.sv
// One key lane: raw and stable levels, long-press flag and two saturating timers.
// Depends on mkdlp_pkg.
module mkdlp_lane #(
  parameter int TIME_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             upd,
  input  logic                             raw,
  input  logic [mkdlp_pkg::ELAPSED_W-1:0]  elapsed,
  input  logic [mkdlp_pkg::DEB_W-1:0]      deb_time,
  input  logic [mkdlp_pkg::LPT_W-1:0]      lpt_time,
  output mkdlp_pkg::lane_stat_t            stat
);
  import mkdlp_pkg::*;

  localparam int CMP_W = (TIME_BITS > LPT_W) ? TIME_BITS : LPT_W;

  logic                 raw_r, stable_r, ld_r;
  logic [TIME_BITS-1:0] sc_r, sp_r;
  logic                 stable_nxt, ld_nxt;
  logic [TIME_BITS-1:0] sc_nxt, sp_nxt;
  logic [TIME_BITS:0]   sc_sum, sp_sum;
  logic [TIME_BITS-1:0] sc_sat, sp_sat;
  logic                 go_stable, ld_mid;

  always_comb begin
    sc_sum     = {1'b0, sc_r} + (TIME_BITS+1)'(elapsed);
    sp_sum     = {1'b0, sp_r} + (TIME_BITS+1)'(elapsed);
    sc_sat     = sc_sum[TIME_BITS] ? '1 : sc_sum[TIME_BITS-1:0];
    sp_sat     = sp_sum[TIME_BITS] ? '1 : sp_sum[TIME_BITS-1:0];
    sc_nxt     = (raw != raw_r) ? '0 : sc_sat;
    go_stable  = (raw != stable_r) && (CMP_W'(sc_nxt) >= CMP_W'(deb_time));
    stable_nxt = go_stable ? raw : stable_r;
    ld_mid     = go_stable ? 1'b0 : ld_r;
    sp_nxt     = (go_stable && raw) ? '0 : sp_sat;
    stat.press_ev = go_stable && raw;
    stat.long_ev  = stable_nxt && !ld_mid && (CMP_W'(sp_nxt) >= CMP_W'(lpt_time));
    stat.stable   = stable_nxt;
    ld_nxt     = stat.long_ev ? 1'b1 : ld_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      ld_r     <= 1'b0;
      sc_r     <= '0;
      sp_r     <= '0;
    end else if (upd) begin
      raw_r    <= raw;
      stable_r <= stable_nxt;
      ld_r     <= ld_nxt;
      sc_r     <= sc_nxt;
      sp_r     <= sp_nxt;
    end
  end

endmodule

### rtl/core/mkdlp_merge.sv
// Merge stage: picks the first key with a new event, holds pending events
// and the output register. Depends on mkdlp_pkg.
module mkdlp_merge #(
  parameter int NUM_KEYS = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_accept,
  input  logic                   take_press,
  input  logic                   take_long,
  input  mkdlp_pkg::lane_stat_t  stat [NUM_KEYS],
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mkdlp_pkg::out_item_t   out_data
);
  import mkdlp_pkg::*;

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic             press_pending_r, long_pending_r;
  logic [IDX_W-1:0] press_idx_r, long_idx_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             any_press, any_long;
  logic [IDX_W-1:0] first_press, first_long;
  logic             press_pending_nxt, long_pending_nxt;
  logic [IDX_W-1:0] press_idx_nxt, long_idx_nxt;
  logic [31:0]      press_wide, long_wide;
  logic [RAW_W-1:0] stable_bits;
  out_item_t        out_data_nxt;

  always_comb begin
    any_press   = 1'b0;
    any_long    = 1'b0;
    first_press = '0;
    first_long  = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (stat[k].press_ev) begin
        any_press   = 1'b1;
        first_press = IDX_W'(k);
      end
      if (stat[k].long_ev) begin
        any_long   = 1'b1;
        first_long = IDX_W'(k);
      end
    end
    stable_bits = '0;
    for (int k = 0; k < RAW_W; k++) begin
      if (k < NUM_KEYS) begin
        stable_bits[k] = stat[k].stable;
      end
    end
  end

  always_comb begin
    press_pending_nxt = press_pending_r || any_press;
    press_idx_nxt     = press_pending_r ? press_idx_r : first_press;
    long_pending_nxt  = long_pending_r || any_long;
    long_idx_nxt      = long_pending_r ? long_idx_r : first_long;
    press_wide        = 32'(press_idx_nxt);
    long_wide         = 32'(long_idx_nxt);
    out_data_nxt.press_valid = press_pending_nxt;
    out_data_nxt.press_key   = press_pending_nxt ? press_wide[KEY_W-1:0] : '0;
    out_data_nxt.long_valid  = long_pending_nxt;
    out_data_nxt.long_key    = long_pending_nxt ? long_wide[KEY_W-1:0] : '0;
    out_data_nxt.stable_keys = stable_bits;
  end

  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_pending_r <= 1'b0;
      long_pending_r  <= 1'b0;
      press_idx_r     <= '0;
      long_idx_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        press_pending_r <= press_pending_nxt && !take_press;
        long_pending_r  <= long_pending_nxt && !take_long;
        press_idx_r     <= press_idx_nxt;
        long_idx_r      <= long_idx_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTH
  a_take_press_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && take_press |=> !press_pending_r)
    else $error("press event still pending after take");

  a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
    press_pending_r && !(in_accept && take_press) |=>
      press_pending_r && press_idx_r == $past(press_idx_r))
    else $error("pending press event lost or changed");

  a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
    long_pending_r && !(in_accept && take_long) |=>
      long_pending_r && long_idx_r == $past(long_idx_r))
    else $error("pending long event lost or changed");

  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.press_valid |-> out_data_r.press_key == '0)
    else $error("press key not zero without event");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");
`endif

endmodule

### rtl/core/multi_key_debounce_long_press_unit.sv
// Top level of the multi-key debounce and long-press unit.
// Instantiates mkdlp_lane per key and mkdlp_merge; depends on mkdlp_pkg.
//
// Each input transaction is one update of all keys: sampled levels, elapsed
// milliseconds and two take flags. Every key has its own lane that debounces
// its level and times the press, and all lanes work in the same cycle; the
// merge stage latches the lowest-index new press or long-press event when none
// is pending. One transaction is taken per clock and its result appears in the
// output register on the next cycle; the input keeps accepting while the output
// register is empty or being drained. Configuration writes are taken at once.
module multi_key_debounce_long_press_unit #(
  parameter int NUM_KEYS  = 5,
  parameter int TIME_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mkdlp_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mkdlp_pkg::out_item_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mkdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mkdlp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mkdlp_pkg::*;

  logic [DEB_W-1:0]   deb_r;
  logic [LPT_W-1:0]   lpt_r;
  logic               in_accept;
  lane_stat_t         stat [NUM_KEYS];

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= DEB_RESET;
      lpt_r <= LPT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_DEBOUNCE) begin
        deb_r <= cfg_data[DEB_W-1:0];
      end else if (cfg_index == REG_LONG_PRESS) begin
        lpt_r <= cfg_data[LPT_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic raw;
    if (k < RAW_W) begin : g_pin
      assign raw = in_data.raw_keys[k];
    end else begin : g_none
      assign raw = 1'b0;
    end
    mkdlp_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd      (in_accept),
      .raw      (raw),
      .elapsed  (in_data.elapsed_ms),
      .deb_time (deb_r),
      .lpt_time (lpt_r),
      .stat     (stat[k])
    );
  end

  mkdlp_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .take_press (in_data.take_press),
    .take_long  (in_data.take_long),
    .stat       (stat),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### dv/multi_key_debounce_long_press_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for multi_key_debounce_long_press_unit: directed and random key
// updates under varied stalls, checked against a predictor held in a scoreboard class.
// Depends on mkdlp_pkg and the unit's RTL.

module multi_key_debounce_long_press_unit_test;
  import mkdlp_pkg::*;

  localparam int KEYS        = 5;
  localparam int TIME_W      = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int SEG_ITEMS   = 325;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd2;

  class key_report_board;
    logic [DEB_W-1:0]  debounce_ms;
    logic [LPT_W-1:0]  long_ms;
    logic              raw_lvl    [KEYS];
    logic              stable_lvl [KEYS];
    logic              long_seen  [KEYS];
    logic [TIME_W-1:0] change_age [KEYS];
    logic [TIME_W-1:0] press_age  [KEYS];
    logic              press_hold;
    logic [KEY_W-1:0]  press_at;
    logic              long_hold;
    logic [KEY_W-1:0]  long_at;
    out_item_t         due_reports[$];
    int                errors;

    function new();
      debounce_ms = DEB_RESET;
      long_ms     = LPT_RESET;
      for (int k = 0; k < KEYS; k++) begin
        raw_lvl[k]    = 1'b0;
        stable_lvl[k] = 1'b0;
        long_seen[k]  = 1'b0;
        change_age[k] = '0;
        press_age[k]  = '0;
      end
      press_hold = 1'b0;
      press_at   = '0;
      long_hold  = 1'b0;
      long_at    = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DEBOUNCE: begin
          debounce_ms = val[DEB_W-1:0];
        end
        REG_LONG_PRESS: begin
          long_ms = val[LPT_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function logic [TIME_W-1:0] age_add(logic [TIME_W-1:0] a, logic [ELAPSED_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + (TIME_W+1)'(b);
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    function void note_update(in_item_t it);
      out_item_t  rep;
      logic       lvl;
      logic [RAW_W-1:0] bits;
      bits = '0;
      for (int k = 0; k < KEYS; k++) begin
        lvl = it.raw_keys[k];
        change_age[k] = age_add(change_age[k], it.elapsed_ms);
        press_age[k]  = age_add(press_age[k], it.elapsed_ms);
        if (lvl != raw_lvl[k]) begin
          raw_lvl[k]    = lvl;
          change_age[k] = '0;
        end
        if (lvl != stable_lvl[k] && change_age[k] >= TIME_W'(debounce_ms)) begin
          stable_lvl[k] = lvl;
          long_seen[k]  = 1'b0;
          if (lvl) begin
            press_age[k] = '0;
            if (!press_hold) begin
              press_hold = 1'b1;
              press_at   = KEY_W'(k);
            end
          end
        end
        if (stable_lvl[k] && !long_seen[k] && press_age[k] >= long_ms) begin
          long_seen[k] = 1'b1;
          if (!long_hold) begin
            long_hold = 1'b1;
            long_at   = KEY_W'(k);
          end
        end
        bits[k] = stable_lvl[k];
      end
      rep.press_valid = press_hold;
      rep.press_key   = press_hold ? press_at : '0;
      rep.long_valid  = long_hold;
      rep.long_key    = long_hold ? long_at : '0;
      rep.stable_keys = bits;
      due_reports.push_back(rep);
      if (it.take_press) press_hold = 1'b0;
      if (it.take_long) long_hold = 1'b0;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("press_valid", 8'(want.press_valid), 8'(got.press_valid));
      compare_field("press_key", 8'(want.press_key), 8'(got.press_key));
      compare_field("long_valid", 8'(want.long_valid), 8'(got.long_valid));
      compare_field("long_key", 8'(want.long_key), 8'(got.long_key));
      compare_field("stable_keys", 8'(want.stable_keys), 8'(got.stable_keys));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  key_report_board board;
  int send_idle = 18;
  int recv_idle = 84;
  int stall_cycles = 0;

  multi_key_debounce_long_press_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) board.check_report(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("multi_key_debounce_long_press_unit test failed");
        $finish;
      end
    end
  end

  function automatic in_item_t mk(int keys, int el, bit tp, bit tl);
    in_item_t it;
    it.raw_keys   = RAW_W'(keys);
    it.elapsed_ms = ELAPSED_W'(el);
    it.take_press = tp;
    it.take_long  = tl;
    return it;
  endfunction

  task automatic send_update(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_update(it);
  endtask

  // hold off until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] deb_word, logic [CFG_DATA_W-1:0] lpt_word);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx[0] = REG_DEBOUNCE;
    idx[1] = REG_LONG_PRESS;
    idx[2] = CFG_IDX_W'($urandom_range(255, REG_FIRST_UNUSED));
    val[0] = deb_word;
    val[1] = lpt_word;
    val[2] = CFG_DATA_W'($urandom_range(16'hFFFF));
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      board.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly held key patterns with occasional edges, plus bounce noise
  task automatic run_random(int count, int churn, int bounce, int big);
    logic [RAW_W-1:0] held;
    in_item_t         it;
    int               sel;
    held = RAW_W'($urandom_range(31));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < churn) begin
        sel = $urandom_range(RAW_W - 1);
        held[sel] = ~held[sel];
      end
      it.raw_keys   = ($urandom_range(99) < bounce) ? RAW_W'($urandom_range(31)) : held;
      it.elapsed_ms = ($urandom_range(99) < big) ? ELAPSED_W'($urandom_range(255, 128))
                                                 : ELAPSED_W'($urandom_range(40));
      it.take_press = ($urandom_range(99) < 35);
      it.take_long  = ($urandom_range(99) < 35);
      send_update(it);
    end
  endtask

  initial begin
    board = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero debounce and zero long-press time
    configure(16'hFF00, 16'h0000);
    send_update(mk(31, 0, 0, 0));
    send_update(mk(31, 255, 1, 1));
    send_update(mk(0, 0, 1, 1));
    send_update(mk(16, 1, 0, 0));
    send_update(mk(17, 0, 1, 0));
    send_update(mk(17, 0, 0, 1));
    send_update(mk(0, 128, 1, 1));
    drain();

    // bounce short of the debounce time, then a held press that turns long
    configure(16'h000A, 16'd300);
    send_update(mk(4, 5, 0, 0));
    send_update(mk(0, 5, 0, 0));
    send_update(mk(4, 9, 0, 0));
    send_update(mk(4, 9, 0, 0));
    send_update(mk(4, 1, 0, 0));
    send_update(mk(6, 200, 1, 0));
    send_update(mk(6, 100, 0, 0));
    send_update(mk(6, 0, 1, 1));
    send_update(mk(0, 85, 1, 1));
    drain();

    configure(16'hABFF, 16'hFFFF);
    send_update(mk(31, 255, 0, 0));
    send_update(mk(31, 255, 0, 0));
    send_update(mk(31, 0, 1, 0));
    send_update(mk(8, 42, 0, 1));
    drain();

    configure(16'h0000, 16'h0000);
    run_random(SEG_ITEMS, 30, 10, 20);
    drain();
    configure(CFG_DATA_W'($urandom_range(40, 1)), CFG_DATA_W'($urandom_range(1500, 50)));
    run_random(SEG_ITEMS, 10, 10, 30);
    drain();

    send_idle = 84;
    recv_idle = 18;
    // slow edges and long gaps drive the counters into saturation
    configure(16'h00FF, 16'hFFFF);
    run_random(SEG_ITEMS, 1, 0, 90);
    drain();
    configure(CFG_DATA_W'($urandom_range(16'hFFFF)), CFG_DATA_W'($urandom_range(4000)));
    run_random(SEG_ITEMS, 10, 10, 40);
    drain();

    send_idle = 0;
    recv_idle = 0;
    configure(16'(DEB_RESET), 16'(LPT_RESET));
    run_random(SEG_ITEMS, 5, 5, 50);
    drain();
    configure(CFG_DATA_W'($urandom_range(60, 1)), CFG_DATA_W'($urandom_range(3000, 100)));
    run_random(SEG_ITEMS, 15, 15, 30);
    drain();
    repeat (2) @(posedge clk);

    if (board.errors == 0 && board.due_reports.size() == 0) begin
      $display("multi_key_debounce_long_press_unit test passed");
    end else begin
      $display("multi_key_debounce_long_press_unit test failed");
    end
    $finish;
  end

endmodule

### multi_key_debounce_long_press_unit.f
rtl/core/mkdlp_pkg.sv
rtl/core/mkdlp_lane.sv
rtl/core/mkdlp_merge.sv
rtl/core/multi_key_debounce_long_press_unit.sv
dv/multi_key_debounce_long_press_unit_test.sv
